// File: hdl/bmp24_pkg.sv
// Shared types and constants for the 24-bit BMP stream decoder.
// Used by the front parser, the word queue, the pixel back end and the top level.
// No dependencies.
package bmp24_pkg;

  // Header limits and queue sizing.
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned DIM_W          = 16;
  localparam int unsigned QUEUE_DEPTH    = 4;

  // File format constants.
  localparam logic [7:0]  MAGIC_B    = 8'h42;
  localparam logic [7:0]  MAGIC_M    = 8'h4D;
  localparam logic [31:0] HLEN_V3    = 32'd40;
  localparam logic [31:0] HLEN_OS2V1 = 32'd12;
  localparam logic [31:0] HLEN_OS2V2 = 32'd64;
  localparam logic [31:0] HLEN_V4    = 32'd108;
  localparam logic [31:0] HLEN_V5    = 32'd124;
  localparam logic [15:0] BPP_24     = 16'd24;

  // Result kinds as seen on the output port.
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Status codes carried by header and error results.
  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_NOT_BM      = 4'd1,
    ST_NOT_24BPP   = 4'd2,
    ST_COMPRESSED  = 4'd3,
    ST_OS2V2       = 4'd4,
    ST_V4          = 4'd5,
    ST_V5          = 4'd6,
    ST_UNKNOWN     = 4'd7,
    ST_OFS_BEHIND  = 4'd8,
    ST_TOO_LARGE   = 4'd9
  } status_e;

  // Operations passed from the front parser to the back end.
  typedef enum logic [1:0] {
    OP_PIX = 2'd0,
    OP_HDR = 2'd1,
    OP_ERR = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    status_e          status;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } q_entry_t;

  // Queue output toward the back end.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

// File: hdl/bmp24_stream_decoder_top.sv
// 24-bit BMP stream decoder, top level.
// Byte input channel: in_valid_i/in_ready_o with data_byte_i and file_start_i.
// A word with file_start_i high is byte 0 of a new file and restarts the parse.
// Result channel: out_valid_o/out_ready_i carrying at most one result per word: a pixel
// (kind 0, RGB and last_pixel), a header (kind 1, width and height) or an error
// (kind 2, status). Bytes outside a file and trailing bytes are dropped silently.
// Throughput: one byte per cycle while the queue has room. The rate is set by the
// front parser, which retires one byte per cycle, and by the single result register
// of the back end. A byte that causes a result is written into the queue when it is
// accepted, and the back end loads that result from the queue head into the output register.
// A four-entry queue parts the parser from the pixel back end. When the
// receiver stalls, the output register holds its result and the queue fills;
// in_ready_o falls once the queue is full and rises as it drains.
// Reset (rst_ni low, asynchronous) empties the queue, clears the output valid
// and puts the parser in its wait-for-file state. No clearing pass is needed.
// Depends on bmp24_pkg, bmp24_front, bmp24_queue and bmp24_back.
module bmp24_stream_decoder_top #(
  parameter int unsigned MAX_WIDTH  = bmp24_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmp24_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [12:0] image_width_o,
  output logic [12:0] image_height_o,
  output logic [3:0]  status_o,
  output logic        last_pixel_o
);

  logic                q_full;
  logic                push;
  bmp24_pkg::q_entry_t push_entry;
  logic                pop;
  bmp24_pkg::q_head_t  head;

  // Header parser and data offset skip.
  bmp24_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .file_start_i (file_start_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // Decoupling queue.
  bmp24_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_o       (head)
  );

  // Pixel assembly and result register.
  bmp24_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o),
    .status_o       (status_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

// File: hdl/bmp24_front.sv
// Front parser: accepts file bytes, decodes the BMP header and skips to the pixel data.
// Pushes pixel bytes, header results and error results into the word queue.
// Depends on bmp24_pkg.
module bmp24_front #(
  parameter int unsigned MAX_WIDTH  = bmp24_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmp24_pkg::MAX_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                file_start_i,
  input  logic                q_full_i,
  output logic                push_o,
  output bmp24_pkg::q_entry_t push_entry_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS
  } phase_e;

  // Byte positions inside the file header.
  localparam logic [4:0] P_MAGIC_END = 5'd1;
  localparam logic [4:0] P_OFS_LO    = 5'd10;
  localparam logic [4:0] P_OFS_END   = 5'd13;
  localparam logic [4:0] P_HLEN_LO   = 5'd14;
  localparam logic [4:0] P_HLEN_END  = 5'd17;
  localparam logic [4:0] P_W_LO      = 5'd18;
  localparam logic [4:0] P_V3_W_END  = 5'd21;
  localparam logic [4:0] P_V3_H_LO   = 5'd22;
  localparam logic [4:0] P_V3_H_END  = 5'd25;
  localparam logic [4:0] P_V3_B_LO   = 5'd28;
  localparam logic [4:0] P_V3_B_END  = 5'd29;
  localparam logic [4:0] P_V3_C_LO   = 5'd30;
  localparam logic [4:0] P_V3_C_END  = 5'd31;
  localparam logic [4:0] P_OS_W_END  = 5'd19;
  localparam logic [4:0] P_OS_H_LO   = 5'd20;
  localparam logic [4:0] P_OS_H_END  = 5'd21;
  localparam logic [4:0] P_OS_B_LO   = 5'd24;
  localparam logic [4:0] P_OS_B_END  = 5'd25;
  localparam logic [32:0] USED_V3    = 33'd32;
  localparam logic [32:0] USED_OS2   = 33'd26;
  localparam logic [31:0] LIM_W      = 32'(MAX_WIDTH);
  localparam logic [31:0] LIM_H      = 32'(MAX_HEIGHT);

  phase_e                      phase_q, phase_d;
  logic [4:0]                  pos_q, pos_d;
  logic [31:0]                 acc_q, acc_d;
  logic [31:0]                 ofs_q, ofs_d;
  logic [31:0]                 rem_q, rem_d;
  logic                        v3_q, v3_d;
  logic [bmp24_pkg::DIM_W-1:0] w_q, w_d, h_q, h_d;
  logic                        w_big_q, w_big_d, h_big_q, h_big_d;

  logic       take;
  phase_e     ph;
  logic [4:0] pos;
  logic       gath;
  logic [4:0] base;
  logic [4:0] rel;
  logic [31:0] acc_cur;
  logic       fin;
  logic [32:0] diff;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign ph         = file_start_i ? PH_HEADER : phase_q;
  assign pos        = file_start_i ? 5'd0 : pos_q;

  // Locate the current header field and the byte lane inside it.
  always_comb begin
    gath = 1'b0;
    base = 5'd0;
    if (pos <= P_MAGIC_END) begin
      gath = 1'b1;
    end else if (pos >= P_OFS_LO && pos <= P_OFS_END) begin
      gath = 1'b1;
      base = P_OFS_LO;
    end else if (pos >= P_HLEN_LO && pos <= P_HLEN_END) begin
      gath = 1'b1;
      base = P_HLEN_LO;
    end else if (v3_q) begin
      if (pos >= P_W_LO && pos <= P_V3_W_END) begin
        gath = 1'b1;
        base = P_W_LO;
      end else if (pos >= P_V3_H_LO && pos <= P_V3_H_END) begin
        gath = 1'b1;
        base = P_V3_H_LO;
      end else if (pos >= P_V3_B_LO && pos <= P_V3_B_END) begin
        gath = 1'b1;
        base = P_V3_B_LO;
      end else if (pos >= P_V3_C_LO && pos <= P_V3_C_END) begin
        gath = 1'b1;
        base = P_V3_C_LO;
      end
    end else begin
      if (pos >= P_W_LO && pos <= P_OS_W_END) begin
        gath = 1'b1;
        base = P_W_LO;
      end else if (pos >= P_OS_H_LO && pos <= P_OS_H_END) begin
        gath = 1'b1;
        base = P_OS_H_LO;
      end else if (pos >= P_OS_B_LO && pos <= P_OS_B_END) begin
        gath = 1'b1;
        base = P_OS_B_LO;
      end
    end
  end

  assign rel = pos - base;

  // Little-endian assembly of the field value including the current byte.
  always_comb begin
    acc_cur = acc_q;
    if (rel[1:0] == 2'd0) begin
      acc_cur = {24'd0, data_byte_i};
    end else begin
      acc_cur[{rel[1:0], 3'b000} +: 8] = data_byte_i;
    end
  end

  // Distance from the bytes consumed by the header to the data offset.
  assign diff = {1'b0, ofs_q} - (v3_q ? USED_V3 : USED_OS2);

  // Parse step for one accepted word.
  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    acc_d        = acc_q;
    ofs_d        = ofs_q;
    rem_d        = rem_q;
    v3_d         = v3_q;
    w_d          = w_q;
    h_d          = h_q;
    w_big_d      = w_big_q;
    h_big_d      = h_big_q;
    push_o       = 1'b0;
    push_entry_o = '0;
    fin          = 1'b0;
    if (take) begin
      case (ph)
        PH_HEADER: begin
          phase_d = PH_HEADER;
          pos_d   = pos + 5'd1;
          if (gath) begin
            acc_d = acc_cur;
          end
          if (pos == P_MAGIC_END) begin
            if (acc_cur[15:0] != {bmp24_pkg::MAGIC_M, bmp24_pkg::MAGIC_B}) begin
              push_o              = 1'b1;
              push_entry_o.op     = bmp24_pkg::OP_ERR;
              push_entry_o.status = bmp24_pkg::ST_NOT_BM;
              phase_d             = PH_IDLE;
            end
          end else if (pos == P_OFS_END) begin
            ofs_d = acc_cur;
          end else if (pos == P_HLEN_END) begin
            v3_d = (acc_cur == bmp24_pkg::HLEN_V3);
            if (acc_cur != bmp24_pkg::HLEN_V3 && acc_cur != bmp24_pkg::HLEN_OS2V1) begin
              push_o          = 1'b1;
              push_entry_o.op = bmp24_pkg::OP_ERR;
              phase_d         = PH_IDLE;
              if (acc_cur == bmp24_pkg::HLEN_OS2V2) begin
                push_entry_o.status = bmp24_pkg::ST_OS2V2;
              end else if (acc_cur == bmp24_pkg::HLEN_V4) begin
                push_entry_o.status = bmp24_pkg::ST_V4;
              end else if (acc_cur == bmp24_pkg::HLEN_V5) begin
                push_entry_o.status = bmp24_pkg::ST_V5;
              end else begin
                push_entry_o.status = bmp24_pkg::ST_UNKNOWN;
              end
            end
          end else if (pos == (v3_q ? P_V3_W_END : P_OS_W_END)) begin
            w_d     = acc_cur[bmp24_pkg::DIM_W-1:0];
            w_big_d = (acc_cur > LIM_W);
          end else if (pos == (v3_q ? P_V3_H_END : P_OS_H_END)) begin
            h_d     = acc_cur[bmp24_pkg::DIM_W-1:0];
            h_big_d = (acc_cur > LIM_H);
          end else if (pos == (v3_q ? P_V3_B_END : P_OS_B_END)) begin
            if (acc_cur[15:0] != bmp24_pkg::BPP_24) begin
              push_o              = 1'b1;
              push_entry_o.op     = bmp24_pkg::OP_ERR;
              push_entry_o.status = bmp24_pkg::ST_NOT_24BPP;
              phase_d             = PH_IDLE;
            end else if (!v3_q) begin
              fin = 1'b1;
            end
          end else if (v3_q && pos == P_V3_C_END) begin
            if (acc_cur[15:0] != 16'd0) begin
              push_o              = 1'b1;
              push_entry_o.op     = bmp24_pkg::OP_ERR;
              push_entry_o.status = bmp24_pkg::ST_COMPRESSED;
              phase_d             = PH_IDLE;
            end else begin
              fin = 1'b1;
            end
          end
          // End of header: size check first, then the data offset.
          if (fin) begin
            push_o = 1'b1;
            if (w_big_q || h_big_q) begin
              push_entry_o.op     = bmp24_pkg::OP_ERR;
              push_entry_o.status = bmp24_pkg::ST_TOO_LARGE;
              phase_d             = PH_IDLE;
            end else if (diff[32]) begin
              push_entry_o.op     = bmp24_pkg::OP_ERR;
              push_entry_o.status = bmp24_pkg::ST_OFS_BEHIND;
              phase_d             = PH_IDLE;
            end else begin
              push_entry_o.op     = bmp24_pkg::OP_HDR;
              push_entry_o.status = bmp24_pkg::ST_OK;
              push_entry_o.width  = w_q;
              push_entry_o.height = h_q;
              rem_d               = diff[31:0];
              if (w_q == '0 || h_q == '0) begin
                phase_d = PH_IDLE;
              end else if (diff[31:0] == 32'd0) begin
                phase_d = PH_PIXELS;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (rem_q == 32'd1) begin
            phase_d = PH_PIXELS;
          end else begin
            rem_d = rem_q - 32'd1;
          end
        end
        PH_PIXELS: begin
          push_o            = 1'b1;
          push_entry_o.op   = bmp24_pkg::OP_PIX;
          push_entry_o.data = data_byte_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      rem_q   <= '0;
      v3_q    <= 1'b0;
      w_big_q <= 1'b0;
      h_big_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      v3_q    <= v3_d;
      w_big_q <= w_big_d;
      h_big_q <= h_big_d;
    end
  end

  // Header field values.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ofs_q <= ofs_d;
    w_q   <= w_d;
    h_q   <= h_d;
  end

endmodule

// File: hdl/bmp24_queue.sv
// Short word queue between the front parser and the pixel back end.
// Lets each side stall on its own. Depends on bmp24_pkg.
module bmp24_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bmp24_pkg::q_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output bmp24_pkg::q_head_t  head_o
);

  localparam int unsigned PTR_W = $clog2(bmp24_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(bmp24_pkg::QUEUE_DEPTH + 1);

  bmp24_pkg::q_entry_t mem_q [bmp24_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_q, rd_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                do_push, do_pop;

  assign full_o       = (cnt_q == CNT_W'(bmp24_pkg::QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(bmp24_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(bmp24_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

endmodule

// File: hdl/bmp24_back.sv
// Pixel back end: turns BGR byte triples into RGB pixels, drops row padding and
// holds the output register for pixel, header and error results. Depends on bmp24_pkg.
module bmp24_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmp24_pkg::q_head_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [12:0]        image_width_o,
  output logic [12:0]        image_height_o,
  output logic [3:0]         status_o,
  output logic               last_pixel_o
);

  localparam int unsigned DW = bmp24_pkg::DIM_W;

  logic          active_q, active_d;
  logic          in_pad_q, in_pad_d;
  logic [1:0]    k_q, k_d;
  logic [1:0]    pad_q, pad_d;
  logic [1:0]    pad_cnt_q, pad_cnt_d;
  logic [DW-1:0] col_q, col_d, row_q, row_d;
  logic [DW-1:0] wm1_q, wm1_d, hm1_q, hm1_d;
  logic [7:0]    b0_q, b0_d, b1_q, b1_d;

  logic             ov_q, ov_d;
  bmp24_pkg::kind_e   kind_q, kind_d;
  bmp24_pkg::status_e st_q, st_d;
  logic [7:0]       r_q, r_d, g_q, g_d, bl_q, bl_d;
  logic [12:0]      w_q, w_d, h_q, h_d;
  logic             last_q, last_d;

  logic                is_last;
  bmp24_pkg::q_entry_t e;

  assign e       = head_i.entry;
  assign pop_o   = head_i.valid && (!ov_q || out_ready_i);
  assign is_last = (row_q == hm1_q) && (col_q == wm1_q);

  // Handle one word from the queue.
  always_comb begin
    active_d  = active_q;
    in_pad_d  = in_pad_q;
    k_d       = k_q;
    pad_d     = pad_q;
    pad_cnt_d = pad_cnt_q;
    col_d     = col_q;
    row_d     = row_q;
    wm1_d     = wm1_q;
    hm1_d     = hm1_q;
    b0_d      = b0_q;
    b1_d      = b1_q;
    ov_d      = ov_q && !out_ready_i;
    kind_d    = kind_q;
    st_d      = st_q;
    r_d       = r_q;
    g_d       = g_q;
    bl_d      = bl_q;
    w_d       = w_q;
    h_d       = h_q;
    last_d    = last_q;
    if (pop_o) begin
      case (e.op)
        bmp24_pkg::OP_HDR: begin
          active_d  = (e.width != '0) && (e.height != '0);
          in_pad_d  = 1'b0;
          k_d       = 2'd0;
          pad_d     = e.width[1:0];
          col_d     = '0;
          row_d     = '0;
          wm1_d     = e.width - DW'(1);
          hm1_d     = e.height - DW'(1);
          ov_d      = 1'b1;
          kind_d    = bmp24_pkg::KIND_HEADER;
          st_d      = bmp24_pkg::ST_OK;
          r_d       = 8'd0;
          g_d       = 8'd0;
          bl_d      = 8'd0;
          w_d       = e.width[12:0];
          h_d       = e.height[12:0];
          last_d    = 1'b0;
        end
        bmp24_pkg::OP_ERR: begin
          active_d = 1'b0;
          ov_d     = 1'b1;
          kind_d   = bmp24_pkg::KIND_ERROR;
          st_d     = e.status;
          r_d      = 8'd0;
          g_d      = 8'd0;
          bl_d     = 8'd0;
          w_d      = 13'd0;
          h_d      = 13'd0;
          last_d   = 1'b0;
        end
        bmp24_pkg::OP_PIX: begin
          if (active_q) begin
            if (in_pad_q) begin
              // Padding at the end of a row.
              if (pad_cnt_q == 2'd1) begin
                in_pad_d = 1'b0;
                row_d    = row_q + DW'(1);
              end else begin
                pad_cnt_d = pad_cnt_q - 2'd1;
              end
            end else begin
              case (k_q)
                2'd0: begin
                  b0_d = e.data;
                  k_d  = 2'd1;
                end
                2'd1: begin
                  b1_d = e.data;
                  k_d  = 2'd2;
                end
                default: begin
                  // Third byte completes the pixel.
                  k_d    = 2'd0;
                  ov_d   = 1'b1;
                  kind_d = bmp24_pkg::KIND_PIXEL;
                  st_d   = bmp24_pkg::ST_OK;
                  r_d    = e.data;
                  g_d    = b1_q;
                  bl_d   = b0_q;
                  w_d    = 13'd0;
                  h_d    = 13'd0;
                  last_d = is_last;
                  if (is_last) begin
                    active_d = 1'b0;
                  end else if (col_q == wm1_q) begin
                    col_d = '0;
                    if (pad_q == 2'd0) begin
                      row_d = row_q + DW'(1);
                    end else begin
                      in_pad_d  = 1'b1;
                      pad_cnt_d = pad_q;
                    end
                  end else begin
                    col_d = col_q + DW'(1);
                  end
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      in_pad_q  <= 1'b0;
      k_q       <= '0;
      pad_cnt_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      active_q  <= active_d;
      in_pad_q  <= in_pad_d;
      k_q       <= k_d;
      pad_cnt_q <= pad_cnt_d;
      col_q     <= col_d;
      row_q     <= row_d;
      ov_q      <= ov_d;
    end
  end

  // Image geometry, byte holding and output payload.
  always_ff @(posedge clk_i) begin
    pad_q  <= pad_d;
    wm1_q  <= wm1_d;
    hm1_q  <= hm1_d;
    b0_q   <= b0_d;
    b1_q   <= b1_d;
    kind_q <= kind_d;
    st_q   <= st_d;
    r_q    <= r_d;
    g_q    <= g_d;
    bl_q   <= bl_d;
    w_q    <= w_d;
    h_q    <= h_d;
    last_q <= last_d;
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = kind_q;
  assign red_o          = r_q;
  assign green_o        = g_q;
  assign blue_o         = bl_q;
  assign image_width_o  = w_q;
  assign image_height_o = h_q;
  assign status_o       = st_q;
  assign last_pixel_o   = last_q;

endmodule
